/* sv/wstg_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the windowed-sinc tap generator.
// Used by every module of the block; depends on nothing.
package wstg_pkg;

  // Field and register widths
  localparam int IDX_W  = 8;
  localparam int LEN_W  = 9;
  localparam int CUT_W  = 16;
  localparam int TAP_W  = 18;
  localparam int STAT_W = 2;
  localparam int K_W    = 11;
  localparam int AK_W   = 9;
  localparam int ACC_W  = 31;
  localparam int XR_W   = 16;
  localparam int INVPI_W = 29;

  // Parameter defaults
  localparam int MAX_TAPS_DEF  = 256;
  localparam int FRAC_BITS_DEF = 16;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EVEN_HP = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_TAP_COUNT = 2'd0;
  localparam logic [1:0] REG_CUTOFF    = 2'd1;
  localparam logic [1:0] REG_TYPE      = 2'd2;

  // Register reset values
  localparam logic [LEN_W-1:0] TAP_COUNT_RST = 9'd31;
  localparam logic [CUT_W-1:0] CUTOFF_RST    = 16'd8192;

  // Tap saturation limits
  localparam logic signed [TAP_W-1:0] TAP_MAX = 18'sd131071;
  localparam logic signed [TAP_W-1:0] TAP_MIN = -18'sd131072;

  // Quarter-sine Taylor coefficients in Q30, highest order first
  localparam logic [ACC_W-1:0] COEF [0:4] = '{
    31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };
  localparam logic [INVPI_W-1:0] INVPI = 29'd341782638;

  // Side data that rides with a word down the pipeline
  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic                    neg;
    logic                    centre;
    logic signed [TAP_W-1:0] centre_val;
    logic [AK_W-1:0]         ak;
  } tag_t;

endpackage

/* sv/windowed_sinc_tap_generator.sv */
`timescale 1ns / 1ps
// Top level of the windowed-sinc tap generator: registers, pipeline, output.
// Depends on wstg_pkg, wstg_sine_pipe and wstg_div_row.
//
//  channel | dir | ports                           | word
//  in      | in  | in_tvalid/tready/tdata[7:0]     | tap_index
//  out     | out | out_tvalid/tready/tdata,tuser   | tap_value, status
//  cfg     | in  | cfg_psel..cfg_pready (APB)      | tap_count, cutoff, type
//
// One word is taken every cycle while the skid register is empty; a word's
// result passes through the status stage, the phase multiply, six sine stages,
// two scaling stages, the FRAC_BITS + 2 cells of the division row, the final
// stage and the output register.
// Synchronous active-low reset clears valid bits and registers to defaults.
// A stalled output holds in the output register and one skid register;
// the pipeline freezes only while the skid register is full.
module windowed_sinc_tap_generator #(
  parameter int MAX_TAPS  = wstg_pkg::MAX_TAPS_DEF,
  parameter int FRAC_BITS = wstg_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] tap_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [17:0] tap_value, [23:18] zero
  output logic [1:0]  out_tuser,   // [1:0] status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SH     = 59 - FRAC_BITS;
  localparam int AW     = 61;
  localparam int QW     = AW - SH;
  localparam int SH_UP  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int SH_DN  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 1;
  localparam int TAP_W  = wstg_pkg::TAP_W;

  // Configuration registers
  logic [wstg_pkg::LEN_W-1:0] tap_count_r;
  logic [wstg_pkg::CUT_W-1:0] cutoff_r;
  logic                       type_r;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= wstg_pkg::TAP_COUNT_RST;
      cutoff_r    <= wstg_pkg::CUTOFF_RST;
      type_r      <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        wstg_pkg::REG_TAP_COUNT: tap_count_r <= cfg_pwdata[8:0];
        wstg_pkg::REG_CUTOFF:    cutoff_r    <= cfg_pwdata[15:0];
        wstg_pkg::REG_TYPE:      type_r      <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      wstg_pkg::REG_TAP_COUNT: cfg_prdata = 32'(tap_count_r);
      wstg_pkg::REG_CUTOFF:    cfg_prdata = 32'(cutoff_r);
      wstg_pkg::REG_TYPE:      cfg_prdata = 32'(type_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // Pipeline advance and input handshake
  logic skid_v_r;
  logic adv;
  logic in_acc;

  assign adv       = !skid_v_r;
  assign in_tready = adv;
  assign in_acc    = in_tvalid && in_tready;

  // Stage A: status, offset and centre tap
  localparam int K_W_C = wstg_pkg::K_W;
  logic signed [K_W_C-1:0] k_s;
  logic signed [K_W_C-1:0] ak_s;
  logic [1:0]              st_a;
  logic [16:0]             two_c;
  logic [33:0]             sc;
  logic signed [34:0]      ctr;
  logic signed [TAP_W-1:0] ctr_sat;
  logic                    a_v_r;
  logic signed [K_W_C-1:0] k_r;
  wstg_pkg::tag_t          tag_a_r;

  always_comb begin
    k_s = $signed({2'b00, in_tdata, 1'b0}) - $signed({2'b00, tap_count_r}) + 11'sd1;
    ak_s = k_s[K_W_C-1] ? -k_s : k_s;
    if (tap_count_r == '0 || 32'(tap_count_r) > MAX_TAPS
        || {1'b0, in_tdata} >= tap_count_r) begin
      st_a = wstg_pkg::ST_RANGE;
    end else if (type_r && !tap_count_r[0]) begin
      st_a = wstg_pkg::ST_EVEN_HP;
    end else begin
      st_a = wstg_pkg::ST_OK;
    end
    two_c = {cutoff_r, 1'b0};
    if (FRAC_BITS >= 16) begin
      sc = 34'(two_c) << SH_UP;
    end else begin
      sc = (34'(two_c) + (34'(1) << (SH_DN - 1))) >> SH_DN;
    end
    ctr = type_r ? (35'sd1 <<< FRAC_BITS) - $signed({1'b0, sc}) : $signed({1'b0, sc});
    if (ctr > 35'(wstg_pkg::TAP_MAX)) begin
      ctr_sat = wstg_pkg::TAP_MAX;
    end else if (ctr < 35'(wstg_pkg::TAP_MIN)) begin
      ctr_sat = wstg_pkg::TAP_MIN;
    end else begin
      ctr_sat = ctr[TAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_r                <= k_s;
      tag_a_r.status     <= st_a;
      tag_a_r.neg        <= k_s[K_W_C-1] ^ type_r;
      tag_a_r.centre     <= (k_s == '0);
      tag_a_r.centre_val <= ctr_sat;
      tag_a_r.ak         <= ak_s[wstg_pkg::AK_W-1:0];
    end
  end

  // Stage B: phase = cutoff * offset, modulo one full turn
  logic [26:0]    pm;
  logic           b_v_r;
  logic [16:0]    p_r;
  wstg_pkg::tag_t tag_b_r;

  assign pm = 27'(cutoff_r) * 27'(k_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r     <= pm[16:0];
      tag_b_r <= tag_a_r;
    end
  end

  // Fold the phase into the first quadrant
  logic [wstg_pkg::XR_W-1:0] xr;
  wstg_pkg::tag_t            tag_c;

  always_comb begin
    xr = p_r[15] ? 16'd32768 - {1'b0, p_r[14:0]} : {1'b0, p_r[14:0]};
    tag_c     = tag_b_r;
    tag_c.neg = tag_b_r.neg ^ p_r[16];
  end

  logic                       sn_v;
  logic [wstg_pkg::ACC_W-1:0] sn_s;
  wstg_pkg::tag_t             sn_tag;

  wstg_sine_pipe u_sine (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (b_v_r),
    .in_xr   (xr),
    .in_tag  (tag_c),
    .out_v   (sn_v),
    .out_s   (sn_s),
    .out_tag (sn_tag)
  );

  // Stage D: multiply by 1/pi
  logic           d_v_r;
  logic [59:0]    num_r;
  wstg_pkg::tag_t tag_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (adv) begin
      d_v_r <= sn_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r   <= 60'(sn_s) * 60'(wstg_pkg::INVPI);
      tag_d_r <= sn_tag;
    end
  end

  // Stage E: add the rounding half and drop the scale bits
  logic [AW-1:0]  a_sum;
  logic           e_v_r;
  logic [QW-1:0]  q0_r;
  wstg_pkg::tag_t tag_e_r;

  assign a_sum = AW'(num_r) + (AW'(tag_d_r.ak) << (SH - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (adv) begin
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q0_r    <= a_sum[AW-1:SH];
      tag_e_r <= tag_d_r;
    end
  end

  // Divide by the offset magnitude
  logic           dv_v;
  logic [QW-1:0]  dv_q;
  wstg_pkg::tag_t dv_tag;

  wstg_div_row #(.QW(QW)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_v    (e_v_r),
    .in_q0   (q0_r),
    .in_tag  (tag_e_r),
    .out_v   (dv_v),
    .out_q   (dv_q),
    .out_tag (dv_tag)
  );

  // Final stage: sign, saturate, select
  logic [31:0]             mag32;
  logic signed [TAP_W-1:0] tap_f;
  logic                    f_v_r;
  logic signed [TAP_W-1:0] f_tap_r;
  logic [1:0]              f_st_r;

  always_comb begin
    mag32 = 32'(dv_q);
    if (dv_tag.status != wstg_pkg::ST_OK) begin
      tap_f = '0;
    end else if (dv_tag.centre) begin
      tap_f = dv_tag.centre_val;
    end else if (dv_tag.neg) begin
      tap_f = (mag32 > 32'd131072) ? wstg_pkg::TAP_MIN : -$signed(mag32[TAP_W-1:0]);
    end else begin
      tap_f = (mag32 > 32'd131071) ? wstg_pkg::TAP_MAX : $signed(mag32[TAP_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (adv) begin
      f_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_tap_r <= tap_f;
      f_st_r  <= dv_tag.status;
    end
  end

  // Output register with skid
  logic                    out_v_r;
  logic signed [TAP_W-1:0] out_tap_r;
  logic [1:0]              out_st_r;
  logic signed [TAP_W-1:0] skid_tap_r;
  logic [1:0]              skid_st_r;
  logic                    out_take;
  logic                    incoming;

  assign out_take = out_v_r && out_tready;
  assign incoming = f_v_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_take) begin
        skid_v_r <= 1'b0;
      end
    end else if (incoming) begin
      if (!out_v_r || out_take) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_take) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) begin
        out_tap_r <= skid_tap_r;
        out_st_r  <= skid_st_r;
      end
    end else if (incoming) begin
      if (!out_v_r || out_take) begin
        out_tap_r <= f_tap_r;
        out_st_r  <= f_st_r;
      end else begin
        skid_tap_r <= f_tap_r;
        skid_st_r  <= f_st_r;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b000000, out_tap_r};
  assign out_tuser  = out_st_r;

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register full while output register empty");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_st_r != wstg_pkg::ST_OK |-> out_tap_r == '0)
    else $error("nonzero tap with error status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_st_r == wstg_pkg::ST_OK || out_st_r == wstg_pkg::ST_EVEN_HP
                 || out_st_r == wstg_pkg::ST_RANGE))
    else $error("undefined status code");

endmodule

/* sv/wstg_sine_pipe.sv */
`timescale 1ns / 1ps
// Six-stage quarter-sine pipeline: square, four Horner steps, final scale.
// Depends on wstg_pkg.
module wstg_sine_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_v,
  input  logic [wstg_pkg::XR_W-1:0]     in_xr,
  input  wstg_pkg::tag_t                in_tag,
  output logic                          out_v,
  output logic [wstg_pkg::ACC_W-1:0]    out_s,
  output wstg_pkg::tag_t                out_tag
);

  logic                         v_r   [0:5];
  wstg_pkg::tag_t               tag_r [0:5];
  logic [wstg_pkg::XR_W-1:0]    xr_r  [0:4];
  logic [wstg_pkg::ACC_W-1:0]   x2_r  [0:3];
  logic [wstg_pkg::ACC_W-1:0]   acc_r [1:4];
  logic [wstg_pkg::ACC_W-1:0]   s_r;
  logic [31:0]                  sq;
  logic [46:0]                  sp;

  // Square the reduced phase
  assign sq = 32'(in_xr) * 32'(in_xr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r[0]  <= sq[30:0];
      xr_r[0]  <= in_xr;
      tag_r[0] <= in_tag;
    end
  end

  // Horner steps
  for (genvar j = 1; j <= 4; j++) begin : g_horner
    logic [wstg_pkg::ACC_W-1:0] acc_prev;
    logic [61:0]                prod;

    if (j == 1) begin : g_first
      assign acc_prev = wstg_pkg::COEF[0];
    end else begin : g_next
      assign acc_prev = acc_r[j-1];
    end
    assign prod = 62'(acc_prev) * 62'(x2_r[j-1]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        acc_r[j] <= wstg_pkg::COEF[j] - prod[60:30];
        xr_r[j]  <= xr_r[j-1];
        tag_r[j] <= tag_r[j-1];
      end
    end

    if (j < 4) begin : g_x2
      always_ff @(posedge clk) begin
        if (en) begin
          x2_r[j] <= x2_r[j-1];
        end
      end
    end
  end

  // Scale by the phase once more
  assign sp = 47'(acc_r[4]) * 47'(xr_r[4]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[5] <= 1'b0;
    end else if (en) begin
      v_r[5] <= v_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r      <= sp[45:15];
      tag_r[5] <= tag_r[4];
    end
  end

  assign out_v   = v_r[5];
  assign out_s   = s_r;
  assign out_tag = tag_r[5];

endmodule

/* sv/wstg_div_cell.sv */
`timescale 1ns / 1ps
// One restoring division cell: produces one quotient bit per word.
// Depends on wstg_pkg.
module wstg_div_cell #(
  parameter int QW = 18
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_v,
  input  logic [wstg_pkg::AK_W-1:0]   in_rem,
  input  logic [QW-1:0]               in_w,
  input  wstg_pkg::tag_t              in_tag,
  output logic                        out_v,
  output logic [wstg_pkg::AK_W-1:0]   out_rem,
  output logic [QW-1:0]               out_w,
  output wstg_pkg::tag_t              out_tag
);

  logic                        v_r;
  logic [wstg_pkg::AK_W-1:0]   rem_r;
  logic [QW-1:0]               w_r;
  wstg_pkg::tag_t              tag_r;
  logic [wstg_pkg::AK_W:0]     trial;
  logic [wstg_pkg::AK_W:0]     diff;
  logic                        fits;

  // Bring down the next dividend bit and try the subtract
  assign trial = {in_rem, in_w[QW-1]};
  assign diff  = trial - {1'b0, in_tag.ak};
  assign fits  = trial >= {1'b0, in_tag.ak};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= fits ? diff[wstg_pkg::AK_W-1:0] : trial[wstg_pkg::AK_W-1:0];
      w_r   <= {in_w[QW-2:0], fits};
      tag_r <= in_tag;
    end
  end

  assign out_v   = v_r;
  assign out_rem = rem_r;
  assign out_w   = w_r;
  assign out_tag = tag_r;

endmodule

/* sv/wstg_div_row.sv */
`timescale 1ns / 1ps
// Row of QW division cells; the quotient leaves the last cell.
// Depends on wstg_pkg and wstg_div_cell.
module wstg_div_row #(
  parameter int QW = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [QW-1:0]     in_q0,
  input  wstg_pkg::tag_t    in_tag,
  output logic              out_v,
  output logic [QW-1:0]     out_q,
  output wstg_pkg::tag_t    out_tag
);

  logic                        v   [0:QW];
  logic [wstg_pkg::AK_W-1:0]   rem [0:QW];
  logic [QW-1:0]               w   [0:QW];
  wstg_pkg::tag_t              tag [0:QW];

  // Start with an empty remainder
  assign v[0]   = in_v;
  assign rem[0] = '0;
  assign w[0]   = in_q0;
  assign tag[0] = in_tag;

  for (genvar i = 0; i < QW; i++) begin : g_cell
    wstg_div_cell #(.QW(QW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (v[i]),
      .in_rem  (rem[i]),
      .in_w    (w[i]),
      .in_tag  (tag[i]),
      .out_v   (v[i+1]),
      .out_rem (rem[i+1]),
      .out_w   (w[i+1]),
      .out_tag (tag[i+1])
    );
  end

  assign out_v   = v[QW];
  assign out_q   = w[QW];
  assign out_tag = tag[QW];

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for windowed_sinc_tap_generator: directed and random tap requests
// under many tap counts, cutoffs and filter types. Depends on wstg_pkg and the block.
module tb_top;

  localparam int GAP_MAX   = 18;
  localparam int SETTLE    = wstg_pkg::FRAC_BITS_DEF + 30;
  localparam int CYCLE_CAP = 600000;

  typedef struct {
    logic signed [wstg_pkg::TAP_W-1:0] tap;
    logic [wstg_pkg::STAT_W-1:0]       status;
  } tap_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [7:0] tap_index
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [17:0] tap_value, [23:18] zero
  logic [1:0]  out_tuser;         // [1:0] status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Shadow copy of the configuration registers
  logic [wstg_pkg::LEN_W-1:0] len_shadow = wstg_pkg::TAP_COUNT_RST;
  logic [wstg_pkg::CUT_W-1:0] cut_shadow = wstg_pkg::CUTOFF_RST;
  logic                       hp_shadow  = 1'b0;

  tap_result_t expected_taps[$];
  int  mismatches = 0;
  int  taps_checked = 0;
  int  cycles = 0;
  bit  gaps_on = 1'b0;
  bit  stalls_on = 1'b0;
  int  stall_left = 0;

  windowed_sinc_tap_generator dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Quarter-wave sine, Q30 in and out, Horner over the Taylor series
  function automatic longint unsigned quarter_wave(longint unsigned x);
    longint unsigned x2, acc;
    x2  = (x * x) >> 30;
    acc = 64'(wstg_pkg::COEF[0]);
    for (int i = 1; i < 5; i++) acc = 64'(wstg_pkg::COEF[i]) - ((acc * x2) >> 30);
    return (acc * x) >> 30;
  endfunction

  // Tap value and status for one index under the current shadow config
  function automatic tap_result_t sinc_tap(logic [7:0] idx);
    tap_result_t res;
    int k, p, quad, r, x, ak;
    longint unsigned s, num, den, mag;
    longint tap;
    bit neg;
    res.tap = '0;
    res.status = wstg_pkg::ST_OK;
    tap = 0;
    if (len_shadow == 0 || len_shadow > wstg_pkg::MAX_TAPS_DEF || idx >= len_shadow) begin
      res.status = wstg_pkg::ST_RANGE;
      return res;
    end
    if (hp_shadow && !len_shadow[0]) begin
      res.status = wstg_pkg::ST_EVEN_HP;
      return res;
    end
    k = 2 * int'(idx) - (int'(len_shadow) - 1);
    if (k == 0) begin
      tap = longint'(cut_shadow) * 2;
      if (hp_shadow) tap = (longint'(1) << wstg_pkg::FRAC_BITS_DEF) - tap;
    end else begin
      p    = (int'(cut_shadow) * k) & 32'h1FFFF;
      quad = p >> 15;
      r    = p & 32'h7FFF;
      x    = quad[0] ? 32768 - r : r;
      s    = quarter_wave(longint'(x) << 15);
      neg  = (quad >= 2) != (k < 0);
      ak   = (k < 0) ? -k : k;
      num  = s * 64'(wstg_pkg::INVPI);
      den  = longint'(ak) << (59 - wstg_pkg::FRAC_BITS_DEF);
      mag  = (num + (den >> 1)) / den;
      if (hp_shadow) neg = !neg;
      tap  = neg ? -longint'(mag) : longint'(mag);
    end
    if (tap > 131071) tap = 131071;
    if (tap < -131072) tap = -131072;
    res.tap = tap[wstg_pkg::TAP_W-1:0];
    return res;
  endfunction

  // Send one tap index, with an optional random gap first
  task automatic send_index(logic [7:0] idx);
    int gap;
    gap = gaps_on ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= idx;
    do @(posedge clk); while (!in_tready);
    expected_taps.push_back(sinc_tap(idx));
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_taps.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      wstg_pkg::REG_TAP_COUNT: len_shadow = value[wstg_pkg::LEN_W-1:0];
      wstg_pkg::REG_CUTOFF:    cut_shadow = value[wstg_pkg::CUT_W-1:0];
      wstg_pkg::REG_TYPE:      hp_shadow  = value[0];
      default: ;
    endcase
  endtask

  task automatic set_filter(int len, int cut, bit hp);
    drain();
    write_reg(wstg_pkg::REG_TAP_COUNT, len);
    write_reg(wstg_pkg::REG_CUTOFF, cut);
    write_reg(wstg_pkg::REG_TYPE, hp);
  endtask

  // Reset config: edges and centre of the 31-tap default plus out-of-range indexes
  task automatic test_reset_defaults();
    send_index(8'd0);
    send_index(8'd15);
    send_index(8'd30);
    send_index(8'd31);
    send_index(8'd255);
  endtask

  // Extremes of length and cutoff, centre taps, parity and range errors
  task automatic test_corner_configs();
    set_filter(1, 0, 1'b0);
    send_index(8'd0);
    send_index(8'd1);
    set_filter(wstg_pkg::MAX_TAPS_DEF, 32768, 1'b0);
    send_index(8'd0);
    send_index(8'd127);
    send_index(8'd128);
    send_index(8'd255);
    set_filter(255, 65535, 1'b0);
    send_index(8'd127);
    send_index(8'd0);
    send_index(8'd254);
    set_filter(255, 65535, 1'b1);
    send_index(8'd127);
    send_index(8'd126);
    send_index(8'd255);
    set_filter(wstg_pkg::MAX_TAPS_DEF, 20000, 1'b1);
    send_index(8'd10);
    send_index(8'd255);
    set_filter(0, 1000, 1'b0);
    send_index(8'd0);
    set_filter(511, 1000, 1'b0);
    send_index(8'd3);
    set_filter(3, 1, 1'b1);
    send_index(8'd0);
    send_index(8'd1);
    send_index(8'd3);
  endtask

  // Random filters, mostly valid indexes, with and without flow gaps
  task automatic test_random_filters();
    int len, cut;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: len = $urandom_range(1, wstg_pkg::MAX_TAPS_DEF);
        1: len = $urandom_range(1, 40);
        2: len = $urandom_range(0, 511);
        default: len = (ph < 6) ? wstg_pkg::MAX_TAPS_DEF : 1;
      endcase
      cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                        : $urandom_range(0, 32768);
      set_filter(len, cut, $urandom_range(0, 1));
      gaps_on   = ph[0];
      stalls_on = ph[1] ^ ph[0];
      for (int i = 0; i < 143; i++) begin
        if (len > 0 && len <= wstg_pkg::MAX_TAPS_DEF && $urandom_range(0, 7) != 0)
          send_index(8'($urandom_range(0, len - 1)));
        else
          send_index(8'($urandom));
      end
    end
  endtask

  // Compare each result word, then choose the next stall
  always @(posedge clk) begin
    tap_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        taps_checked++;
        if (expected_taps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word tap=%0d status=%0d",
                                         $signed(out_tdata[17:0]), out_tuser);
        end else begin
          want = expected_taps.pop_front();
          if (out_tdata[17:0] !== want.tap || out_tuser !== want.status
              || out_tdata[23:18] !== 6'd0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected tap=%0d status=%0d, got tap=%0d status=%0d",
                       want.tap, want.status, $signed(out_tdata[17:0]), out_tuser);
          end
        end
        stall_left = stalls_on ? $urandom_range(0, GAP_MAX) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_corner_configs();
    test_random_filters();
    drain();
    $display("Checked %0d tap words over directed corners and 12 random filter setups,",
             taps_checked);
    $display("with random input gaps and output stalls; %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
